// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace block
// Window geometry, register codes, the cell control bundle and the record
// that carries the result bytes of one input transfer to the output side.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int SEQ_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
	localparam int REC_LEN     = SEQ_MAX + 1;
	localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
	localparam int LEN_W       = 4;
	localparam int CNT_W       = $clog2(REC_LEN + 1);
	localparam int IDX_W       = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_LEN    = 2'd1,
		REG_REPLACE_BYTES  = 2'd2,
		REG_REPLACE_LEN    = 2'd3
	} reg_idx_t;

	// per-transfer control shared by all window cells
	typedef struct packed {
		logic en;    // input transfer this cycle
		logic pre;   // oldest byte leaves before the new byte enters
		logic post;  // oldest byte leaves after the compare
	} cell_ctl_t;

	// result bytes caused by one input transfer, oldest first
	typedef struct packed {
		logic [REC_LEN-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    bare;
		logic                    last;
	} rec_t;

endpackage

// ----- rtl/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace: streaming byte find-and-replace
// Replaces each leftmost, non-overlapping occurrence of a configured
// pattern in a byte stream by a configured replacement.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes pattern
//    bytes, pattern length, replacement bytes and replacement length. Write
//    only while the block is idle. cfg_ready is always high.
//  - Input channel (in_valid/in_ready) takes one byte per transfer, with
//    in_last marking the end of a stream, which flushes the window.
//  - Result channel (res_valid/res_ready) gives out_byte/out_valid/out_last;
//    out_valid low marks a bare end marker, out_last the final result.
//  - Each input transfer causes 0 to 9 result transfers. They are first
//    visible once the record has been registered in the record buffer and
//    has then moved into the output serializer.
//  - Throughput: one input byte per cycle as long as each byte causes at
//    most one result and the receiver takes each result; a match with a
//    long replacement or a flush holds the input until the output
//    serializer frees up; it sends one result transfer per cycle while res_ready is high.
//  - When the receiver stalls, one more input transfer that has results is
//    still taken into the record buffer; then in_ready drops until the serializer frees up.
//  - Reset clears the registers, empties the window and drops any pending
//    results.
// ----------------------------------------------------------------------------
module stream_find_replace
	import sfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [8*SEQ_MAX-1:0]   cfg_data,
	// input stream
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	// result stream
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [7:0]             out_byte,
	output logic                   out_valid,
	output logic                   out_last
);

	// configuration registers
	logic [8*PATTERN_MAX-1:0] pat_q;
	logic [LEN_W-1:0]         plen_q;
	logic [8*REPLACE_MAX-1:0] repl_q;
	logic [LEN_W-1:0]         rlen_q;

	// window state
	logic [FILL_W-1:0]        fill_q;
	logic [PATTERN_MAX-1:0][7:0] wq;   // stored window bytes
	logic [PATTERN_MAX-1:0][7:0] ww;   // window after pop and append
	logic [PATTERN_MAX-1:0]   eq;
	logic [PATTERN_MAX-1:0]   take;
	logic [PATTERN_MAX-1:0]   mask;

	logic [FILL_W-1:0] plen_e, f1, f2, fill_nx;
	logic [LEN_W-1:0]  rlen_e;
	logic              accept, match, push, push_ready;
	logic [CNT_W-1:0]  cnt_a;
	logic [SEQ_MAX-1:0][7:0] seq_a;
	cell_ctl_t         ctl;
	rec_t              rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			repl_q <= '0;
			rlen_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PATTERN_BYTES: pat_q  <= cfg_data[8*PATTERN_MAX-1:0];
				REG_PATTERN_LEN:   plen_q <= cfg_data[LEN_W-1:0];
				REG_REPLACE_BYTES: repl_q <= cfg_data[8*REPLACE_MAX-1:0];
				REG_REPLACE_LEN:   rlen_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// lengths above the window size count as the window size
	assign plen_e = (plen_q > LEN_W'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX) : FILL_W'(plen_q);
	assign rlen_e = (rlen_q > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_q;

	assign accept = in_valid && in_ready;

	// early pop: window already at pattern length before the new byte
	assign ctl.pre = (fill_q != '0) && (fill_q >= plen_e);
	assign f1      = fill_q - FILL_W'(ctl.pre);
	assign f2      = f1 + FILL_W'(1);
	assign ctl.en  = accept;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			take[i] = (f1 == FILL_W'(i));
			mask[i] = (FILL_W'(i) < plen_e);
		end
	end

	assign match    = (plen_e != '0) && (f2 == plen_e) && (&(eq | ~mask));
	assign ctl.post = !match && (f2 >= plen_e);

	// row of window cells, each shifting toward position 0
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] rq, rw;
		if (i == PATTERN_MAX - 1) begin : g_end
			assign rq = 8'h00;
			assign rw = 8'h00;
		end else begin : g_mid
			assign rq = wq[i+1];
			assign rw = ww[i+1];
		end
		sfr_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.take     (take[i]),
			.in_byte  (in_byte),
			.right_q  (rq),
			.right_w  (rw),
			.pat_byte (pat_q[8*i +: 8]),
			.byte_q   (wq[i]),
			.byte_w   (ww[i]),
			.eq       (eq[i])
		);
	end

	// fill count: a match or end of stream empties the window
	always_comb begin
		if (match || in_last) begin
			fill_nx = '0;
		end else if (ctl.post) begin
			fill_nx = f2 - FILL_W'(1);
		end else begin
			fill_nx = f2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nx;
		end
	end

	// bytes following the early pop: replacement on a match, else the
	// window (whole window on a flush, its oldest byte otherwise)
	always_comb begin
		for (int k = 0; k < SEQ_MAX; k++) begin
			seq_a[k] = 8'h00;
			if (match) begin
				if (k < REPLACE_MAX) seq_a[k] = repl_q[8*k +: 8];
			end else begin
				if (k < PATTERN_MAX) seq_a[k] = ww[k];
			end
		end
		if (match) begin
			cnt_a = CNT_W'(rlen_e);
		end else if (in_last) begin
			cnt_a = CNT_W'(f2);
		end else begin
			cnt_a = CNT_W'(ctl.post);
		end
	end

	// assemble the record; early-popped byte goes first
	always_comb begin
		rec.bytes[0] = ctl.pre ? wq[0] : seq_a[0];
		for (int k = 1; k < REC_LEN; k++) begin
			if (ctl.pre) begin
				rec.bytes[k] = seq_a[k-1];
			end else if (k < SEQ_MAX) begin
				rec.bytes[k] = seq_a[k];
			end else begin
				rec.bytes[k] = 8'h00;
			end
		end
		rec.cnt  = cnt_a + CNT_W'(ctl.pre);
		rec.bare = 1'b0;
		rec.last = in_last;
		// end of stream with nothing to send: bare end marker
		if (in_last && (rec.cnt == '0)) begin
			rec.cnt  = CNT_W'(1);
			rec.bare = 1'b1;
		end
	end

	assign in_ready = push_ready;
	assign push     = accept && (rec.cnt != '0);

	sfr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rec        (rec),
		.push_ready (push_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.out_last   (out_last)
	);

endmodule

// ----- rtl/sfr_cell.sv -----
// ----------------------------------------------------------------------------
// sfr_cell: one byte position of the search window
// Holds a window byte, takes the new byte or its neighbor's byte, and
// compares the updated byte against its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell
	import sfr_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      take,
	input  logic [7:0] in_byte,
	input  logic [7:0] right_q,
	input  logic [7:0] right_w,
	input  logic [7:0] pat_byte,
	output logic [7:0] byte_q,
	output logic [7:0] byte_w,
	output logic      eq
);

	// window after the early pop and the append
	assign byte_w = take ? in_byte : (ctl.pre ? right_q : byte_q);
	assign eq     = (byte_w == pat_byte);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			byte_q <= ctl.post ? right_w : byte_w;
		end
	end

endmodule

// ----- rtl/sfr_emit.sv -----
// ----------------------------------------------------------------------------
// sfr_emit: record buffer and output serializer
// A one-entry buffer decouples input from output; the serializer shifts
// the current record out one result transfer at a time.
// ----------------------------------------------------------------------------
module sfr_emit
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rec_t       rec,
	output logic       push_ready,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	rec_t                    buf_q;
	logic                    buf_full_q;
	logic [REC_LEN-1:0][7:0] sb_q;
	logic [CNT_W-1:0]        scnt_q;
	logic                    sbare_q;
	logic                    slast_q;

	logic busy, ser_free, move;

	assign busy       = (scnt_q != '0);
	assign ser_free   = !busy || ((scnt_q == CNT_W'(1)) && res_ready);
	assign move       = buf_full_q && ser_free;
	assign push_ready = !buf_full_q || move;

	assign res_valid = busy;
	assign out_byte  = sbare_q ? 8'h00 : sb_q[0];
	assign out_valid = !sbare_q;
	assign out_last  = slast_q && (scnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_full_q <= 1'b0;
			scnt_q     <= '0;
		end else begin
			if (push) begin
				buf_full_q <= 1'b1;
			end else if (move) begin
				buf_full_q <= 1'b0;
			end
			if (move) begin
				scnt_q <= buf_q.cnt;
			end else if (busy && res_ready) begin
				scnt_q <= scnt_q - CNT_W'(1);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q <= rec;
		end
		if (move) begin
			sb_q    <= buf_q.bytes;
			sbare_q <= buf_q.bare;
			slast_q <= buf_q.last;
		end else if (busy && res_ready) begin
			for (int k = 0; k < REC_LEN - 1; k++) begin
				sb_q[k] <= sb_q[k+1];
			end
			sb_q[REC_LEN-1] <= 8'h00;
		end
	end

endmodule
